// File: rtl/core/kats_pkg.sv
`default_nettype none
package kats_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = 6;
	localparam int Q_DEPTH = 2;
	localparam int QP_W = 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [31:0]        lower_freq;
		logic [31:0]        upper_freq;
		logic signed [31:0] strength_in;
		logic [31:0]        frame_count_in;
		logic               overwrite;
		logic               dump;
	} item_t;

	typedef struct packed {
		logic               is_entry;
		logic [5:0]         entry_count;
		logic               dropped_full;
		logic [31:0]        out_lower;
		logic [31:0]        out_upper;
		logic signed [31:0] out_strength;
		logic [31:0]        out_frames;
		logic               last;
	} result_t;

	typedef struct packed {
		logic  valid;
		item_t data;
	} q_head_t;

	localparam logic signed [31:0] STR_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] STR_MIN = 32'sh8000_0000;

	function automatic logic signed [31:0] sat_add(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? STR_MIN : STR_MAX;
		end
		return s[31:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/kats_if.sv
`default_nettype none
interface kats_in_if;
	logic                 valid;
	logic                 ready;
	kats_pkg::item_t      data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface kats_out_if;
	logic                 valid;
	logic                 ready;
	kats_pkg::result_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/keyed_accumulate_table_sort_top.sv
// Keyed accumulate table with descending sort.
// items (sink): one add per beat, keyed by lower/upper frequency; strength
// overwrites or saturating-accumulates on a match, otherwise a new entry is
// appended (dropped and flagged once 32 entries are held).
// results (source): one acknowledgement beat per add carrying the entry count;
// with dump set, it is followed by every entry in descending strength order,
// ties in storage order, the table being left in that order. last marks the
// final beat of each add.
// A two-entry queue decouples intake from the table engine, so adds are taken
// while the engine works or the output waits.
// Each add is taken from the queue head in the idle state, then compared,
// updated and acknowledged by the engine in that order; the next add is taken
// only once the engine is back in idle. A dump adds N sort passes plus N emit
// beats, N the number of held entries (at most 32).
// Reset empties the table and queue. A stalled receiver holds the output
// register; the engine waits and the queue fills, then items.ready drops.
`default_nettype none
module keyed_accumulate_table_sort_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kats_in_if.sink    items,
	kats_out_if.source results
);
	import kats_pkg::*;

	q_head_t head;
	logic    pop;

	kats_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.pop    (pop),
		.head   (head)
	);

	kats_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.data.entry_count <= 6'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.data.dropped_full)
			|-> results.data.entry_count == 6'(TABLE_DEPTH))
		else $error("drop flagged while table not full");

	a_ack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.data.is_entry)
			|-> (results.data.out_strength == 0 && results.data.out_frames == 0))
		else $error("acknowledgement carries entry data");

endmodule
`default_nettype wire

// File: rtl/core/kats_queue.sv
`default_nettype none
module kats_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	kats_in_if.sink              items,
	input  wire logic            pop,
	output kats_pkg::q_head_t    head
);
	import kats_pkg::*;

	item_t            mem_q [Q_DEPTH];
	logic [QP_W-1:0]  wr_q;
	logic [QP_W-1:0]  rd_q;
	logic [QP_W:0]    fill_q;
	logic             push;
	logic             do_pop;

	assign items.ready = fill_q != (QP_W+1)'(Q_DEPTH);
	assign push = items.valid && items.ready;
	assign head.valid = fill_q != '0;
	assign head.data = mem_q[rd_q];
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= items.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			fill_q <= fill_q + (QP_W+1)'(push) - (QP_W+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/kats_table.sv
`default_nettype none
module kats_table (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  kats_pkg::q_head_t    head,
	output logic                 pop,
	kats_out_if.source           results
);
	import kats_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_CMP, ST_UPD, ST_ACK, ST_SORT, ST_EMIT} state_t;

	state_t              state_q;
	logic [31:0]         lo_q [TABLE_DEPTH];
	logic [31:0]         up_q [TABLE_DEPTH];
	logic signed [31:0]  st_q [TABLE_DEPTH];
	logic [31:0]         fr_q [TABLE_DEPTH];
	cnt_t                held_q;
	item_t               cur_q;
	logic                found_q;
	idx_t                idx_q;
	logic                dropped_q;
	cnt_t                pass_q;
	cnt_t                emit_q;
	logic                out_valid_q;
	result_t             out_q;
	logic [TABLE_DEPTH-1:0] hit;
	idx_t                first;
	logic                slot_free;
	logic                do_dump;
	logic                load_out;
	result_t             next_out;

	assign pop = (state_q == ST_IDLE);
	assign results.valid = out_valid_q;
	assign results.data = out_q;
	assign slot_free = !out_valid_q || results.ready;
	assign do_dump = cur_q.dump && (held_q != '0);
	assign load_out = slot_free && (state_q == ST_ACK || state_q == ST_EMIT);

	always_comb begin
		first = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit[i] = (CNT_W'(i) < held_q) && (lo_q[i] == cur_q.lower_freq)
				&& (up_q[i] == cur_q.upper_freq);
		end
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) first = IDX_W'(i);
		end
	end

	// next output beat: acknowledgement in the ack state, entry while emitting
	always_comb begin
		next_out = '0;
		next_out.entry_count = held_q;
		next_out.dropped_full = dropped_q;
		if (state_q == ST_EMIT) begin
			next_out.is_entry = 1'b1;
			next_out.out_lower = lo_q[emit_q[IDX_W-1:0]];
			next_out.out_upper = up_q[emit_q[IDX_W-1:0]];
			next_out.out_strength = st_q[emit_q[IDX_W-1:0]];
			next_out.out_frames = fr_q[emit_q[IDX_W-1:0]];
			next_out.last = emit_q == held_q - 1'b1;
		end else begin
			next_out.last = !do_dump;
		end
	end

	// table storage: no reset, only entries below the count are read
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			if (found_q) begin
				st_q[idx_q] <= cur_q.overwrite ? cur_q.strength_in
					: sat_add(st_q[idx_q], cur_q.strength_in);
				fr_q[idx_q] <= cur_q.frame_count_in;
			end else if (held_q < CNT_W'(TABLE_DEPTH)) begin
				lo_q[held_q[IDX_W-1:0]] <= cur_q.lower_freq;
				up_q[held_q[IDX_W-1:0]] <= cur_q.upper_freq;
				st_q[held_q[IDX_W-1:0]] <= cur_q.strength_in;
				fr_q[held_q[IDX_W-1:0]] <= cur_q.frame_count_in;
			end
		end else if (state_q == ST_SORT) begin
			// odd-even transposition pass; strict compare keeps ties in order
			for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
				if ((1'(j) == pass_q[0]) && (CNT_W'(j + 1) < held_q)
					&& (st_q[j] < st_q[j+1])) begin
					lo_q[j] <= lo_q[j+1];
					up_q[j] <= up_q[j+1];
					st_q[j] <= st_q[j+1];
					fr_q[j] <= fr_q[j+1];
					lo_q[j+1] <= lo_q[j];
					up_q[j+1] <= up_q[j];
					st_q[j+1] <= st_q[j];
					fr_q[j+1] <= fr_q[j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q <= '0;
			out_valid_q <= 1'b0;
			cur_q <= '0;
			found_q <= 1'b0;
			idx_q <= '0;
			dropped_q <= 1'b0;
			pass_q <= '0;
			emit_q <= '0;
			out_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_q <= next_out;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						cur_q <= head.data;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					found_q <= |hit;
					idx_q <= first;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					dropped_q <= 1'b0;
					if (!found_q) begin
						if (held_q < CNT_W'(TABLE_DEPTH)) held_q <= held_q + 1'b1;
						else dropped_q <= 1'b1;
					end
					state_q <= ST_ACK;
				end
				ST_ACK: begin
					if (slot_free) begin
						pass_q <= '0;
						state_q <= do_dump ? ST_SORT : ST_IDLE;
					end
				end
				ST_SORT: begin
					pass_q <= pass_q + 1'b1;
					if (pass_q == held_q - 1'b1) begin
						emit_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						emit_q <= emit_q + 1'b1;
						if (emit_q == held_q - 1'b1) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
